>>> hdl/mpct_pkg.sv
// ----------------------------------------------------------------------------
// mpct_pkg: shared definitions for the mouse packet cursor tracker
// Field positions of the PS/2 status byte, register indexes, reset values
// and the button flag group passed from the decoder to the top level.
// ----------------------------------------------------------------------------
package mpct_pkg;

   // Position width default
   localparam int COORD_BITS_DEFAULT = 12;

   // Fixed field widths
   localparam int BYTE_BITS  = 8;
   localparam int SIZE_BITS  = 13;
   localparam int STEPX_BITS = 9;
   localparam int STEPY_BITS = 10;
   localparam int CSR_IDX_BITS = 4;

   // Size register reset values
   localparam logic [SIZE_BITS-1:0] SCREEN_WIDE_RESET = 13'd640;
   localparam logic [SIZE_BITS-1:0] SCREEN_TALL_RESET = 13'd480;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_WIDE = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_TALL = 4'd1;

   // Status byte bit positions
   localparam int ST_LEFT  = 0;
   localparam int ST_RIGHT = 1;
   localparam int ST_MID   = 2;
   localparam int ST_XSIGN = 4;
   localparam int ST_YSIGN = 5;
   localparam int ST_XOVF  = 6;
   localparam int ST_YOVF  = 7;

   // Button flags of one packet
   typedef struct packed {
      logic left;
      logic right;
      logic middle;
      logic any;
   } button_type;

   // Reset position: half the size, clamped into 0..bound-1
   function automatic int reset_pos(int size, int cb);
      int half;
      int top;
      half = size / 2;
      if (size == 0) begin
         top = 0;
      end else if (size > (1 << cb)) begin
         top = (1 << cb) - 1;
      end else begin
         top = size - 1;
      end
      return (half > top) ? top : half;
   endfunction

endpackage

>>> hdl/mpct_decode.sv
// ----------------------------------------------------------------------------
// mpct_decode: PS/2 packet field decoder
// Pulls the button flags out of the status byte and forms the signed x
// step and the screen-oriented (downward positive) y step.
// ----------------------------------------------------------------------------
module mpct_decode (
   input  logic [mpct_pkg::BYTE_BITS-1:0]          status_byte,
   input  logic [mpct_pkg::BYTE_BITS-1:0]          x_move_byte,
   input  logic [mpct_pkg::BYTE_BITS-1:0]          y_move_byte,
   output mpct_pkg::button_type                    buttons,
   output logic signed [mpct_pkg::STEPX_BITS-1:0]  step_x,
   output logic signed [mpct_pkg::STEPY_BITS-1:0]  step_y
);
   import mpct_pkg::*;

   logic signed [STEPY_BITS-1:0] dy;

   // Buttons; bit 3 is the always-one marker and is ignored
   always_comb begin
      buttons.left   = status_byte[ST_LEFT];
      buttons.right  = status_byte[ST_RIGHT];
      buttons.middle = status_byte[ST_MID];
      buttons.any    = status_byte[ST_LEFT] | status_byte[ST_RIGHT] | status_byte[ST_MID];
   end

   // x step: 9-bit two's complement, zero on overflow
   assign step_x = status_byte[ST_XOVF] ? '0 : {status_byte[ST_XSIGN], x_move_byte};

   // y step: negate the 9-bit dy so that down is positive, zero on overflow
   assign dy     = {{2{status_byte[ST_YSIGN]}}, y_move_byte};
   assign step_y = status_byte[ST_YOVF] ? '0 : -dy;

endmodule

>>> hdl/mpct_axis.sv
// ----------------------------------------------------------------------------
// mpct_axis: one cursor axis
// Holds the position, adds the step and clamps the sum into 0..size-1,
// with a size of zero held at 0 and sizes past the coordinate range capped.
// ----------------------------------------------------------------------------
module mpct_axis #(
   parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEFAULT,
   parameter logic [COORD_BITS-1:0] RESET_POS = '0
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  logic [mpct_pkg::SIZE_BITS-1:0]          size,
   input  logic signed [mpct_pkg::STEPY_BITS-1:0]  step,
   output logic [COORD_BITS-1:0]                   pos
);
   import mpct_pkg::*;

   localparam int SUM_BITS = COORD_BITS + 2;
   localparam int CMP_BITS = (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;
   localparam logic [CMP_BITS-1:0] CAP = CMP_BITS'(1) << COORD_BITS;

   logic [COORD_BITS-1:0]      pos_ff;
   logic [COORD_BITS-1:0]      pos_in;
   logic [CMP_BITS-1:0]        size_w;
   logic [COORD_BITS-1:0]      top;
   logic signed [SUM_BITS-1:0] step_w;
   logic signed [SUM_BITS-1:0] sum;

   // Largest legal coordinate for the current size
   always_comb begin
      size_w = CMP_BITS'(size);
      if (size_w == '0) begin
         top = '0;
      end else if (size_w > CAP) begin
         top = '1;
      end else begin
         top = COORD_BITS'(size_w - CMP_BITS'(1));
      end
   end

   // Add and clamp
   assign step_w = SUM_BITS'(step);
   assign sum    = $signed({2'b00, pos_ff}) + step_w;

   always_comb begin
      if (sum[SUM_BITS-1]) begin
         pos_in = '0;
      end else if (sum[COORD_BITS:0] > {1'b0, top}) begin
         pos_in = top;
      end else begin
         pos_in = sum[COORD_BITS-1:0];
      end
   end

   // Position register, loaded with each result
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= RESET_POS;
      end else if (advance) begin
         pos_ff <= pos_in;
      end
   end

   assign pos = pos_ff;

endmodule

>>> hdl/mouse_packet_cursor_tracker.sv
// ----------------------------------------------------------------------------
// mouse_packet_cursor_tracker: PS/2 mouse packet decoder with clamped cursor
// Decodes one three-byte packet per word and tracks a cursor on screen.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one packet (status, x, y bytes) per word; rsp_* returns
//   the button flags, both signed steps and the cursor position after the
//   packet. Both channels use valid/stall; a word moves when valid is high
//   and stall is low.
//   csr_* writes the screen width (index 0) and height (index 1); it is
//   always ready. Write only while no packet is in flight; a new size takes
//   effect at the next packet and does not move the cursor.
//   The accepting edge loads the input register; decode, add and clamp then
//   load the result register, from which the result word is taken.
//   Throughput: one packet per cycle while the output is not stalled, set by
//   the single add-and-clamp step on the position registers.
//   Reset: sizes return to 640 x 480, the cursor to the screen center and
//   both pipeline stages empty.
//   Stall: a stalled result holds; one more packet is held in the input
//   register, then req_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module mouse_packet_cursor_tracker #(
   parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // packet input
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [mpct_pkg::BYTE_BITS-1:0]          req_status_byte,
   input  logic [mpct_pkg::BYTE_BITS-1:0]          req_x_move_byte,
   input  logic [mpct_pkg::BYTE_BITS-1:0]          req_y_move_byte,
   // result output
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_left_pressed,
   output logic                                    rsp_right_pressed,
   output logic                                    rsp_middle_pressed,
   output logic                                    rsp_any_pressed,
   output logic signed [mpct_pkg::STEPX_BITS-1:0]  rsp_step_x,
   output logic signed [mpct_pkg::STEPY_BITS-1:0]  rsp_step_y,
   output logic [COORD_BITS-1:0]                   rsp_cursor_col,
   output logic [COORD_BITS-1:0]                   rsp_cursor_row,
   // register writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [mpct_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [mpct_pkg::SIZE_BITS-1:0]          csr_data
);
   import mpct_pkg::*;

   localparam logic [COORD_BITS-1:0] RESET_COL =
      COORD_BITS'(reset_pos(int'(SCREEN_WIDE_RESET), COORD_BITS));
   localparam logic [COORD_BITS-1:0] RESET_ROW =
      COORD_BITS'(reset_pos(int'(SCREEN_TALL_RESET), COORD_BITS));

   logic [SIZE_BITS-1:0]  wide_ff;
   logic [SIZE_BITS-1:0]  tall_ff;

   logic                  in_vld_ff;
   logic [BYTE_BITS-1:0]  in_status_ff;
   logic [BYTE_BITS-1:0]  in_x_ff;
   logic [BYTE_BITS-1:0]  in_y_ff;
   logic                  in_load;

   logic                  out_vld_ff;
   logic                  out_vld_in;
   button_type            btn_ff;
   logic signed [STEPX_BITS-1:0] stepx_ff;
   logic signed [STEPY_BITS-1:0] stepy_ff;

   button_type            dec_btn;
   logic signed [STEPX_BITS-1:0] dec_step_x;
   logic signed [STEPY_BITS-1:0] dec_step_y;
   logic signed [STEPY_BITS-1:0] dec_step_x_w;

   logic                  advance;
   logic                  out_open;

   // Register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff <= SCREEN_WIDE_RESET;
         tall_ff <= SCREEN_TALL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SCREEN_WIDE: wide_ff <= csr_data;
            CSR_SCREEN_TALL: tall_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Pipeline flow control
   assign out_open  = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && out_open;
   assign in_load   = !in_vld_ff || out_open;
   assign req_stall = !in_load;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (in_load) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_status_ff <= req_status_byte;
         in_x_ff      <= req_x_move_byte;
         in_y_ff      <= req_y_move_byte;
      end
   end

   // Decode
   mpct_decode u_decode (
      .status_byte (in_status_ff),
      .x_move_byte (in_x_ff),
      .y_move_byte (in_y_ff),
      .buttons     (dec_btn),
      .step_x      (dec_step_x),
      .step_y      (dec_step_y)
   );

   assign dec_step_x_w = STEPY_BITS'(dec_step_x);

   // Cursor axes; the position registers double as result fields
   mpct_axis #(
      .COORD_BITS (COORD_BITS),
      .RESET_POS  (RESET_COL)
   ) u_axis_col (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .size    (wide_ff),
      .step    (dec_step_x_w),
      .pos     (rsp_cursor_col)
   );

   mpct_axis #(
      .COORD_BITS (COORD_BITS),
      .RESET_POS  (RESET_ROW)
   ) u_axis_row (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .size    (tall_ff),
      .step    (dec_step_y),
      .pos     (rsp_cursor_row)
   );

   // Result register
   always_comb begin
      out_vld_in = out_vld_ff;
      if (out_open) begin
         out_vld_in = in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         btn_ff   <= dec_btn;
         stepx_ff <= dec_step_x;
         stepy_ff <= dec_step_y;
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_left_pressed   = btn_ff.left;
   assign rsp_right_pressed  = btn_ff.right;
   assign rsp_middle_pressed = btn_ff.middle;
   assign rsp_any_pressed    = btn_ff.any;
   assign rsp_step_x         = stepx_ff;
   assign rsp_step_y         = stepy_ff;

endmodule

>>> hdl/mpct_checker.sv
// ----------------------------------------------------------------------------
// mpct_checker: port-level checks for the mouse packet cursor tracker
// Watches the top level's ports and flags flow-control and result slips.
// ----------------------------------------------------------------------------
module mpct_checker #(
   parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_stall,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic                                    rsp_left_pressed,
   input  logic                                    rsp_right_pressed,
   input  logic                                    rsp_middle_pressed,
   input  logic                                    rsp_any_pressed,
   input  logic signed [mpct_pkg::STEPY_BITS-1:0]  rsp_step_y,
   input  logic [COORD_BITS-1:0]                   rsp_cursor_col,
   input  logic [COORD_BITS-1:0]                   rsp_cursor_row
);
   import mpct_pkg::*;

   // A stalled result word holds its position fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cursor_col)
                                 && $stable(rsp_cursor_row))
      else $error("stalled result word changed");

   // Input stalls only while a result is stuck at the output
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

   // Pipeline comes out of reset empty and open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // Any-button flag agrees with the three button flags
   a_any_button: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_any_pressed ==
                    (rsp_left_pressed || rsp_right_pressed || rsp_middle_pressed))
      else $error("any-button flag inconsistent");

   // The downward y step never reaches -256
   a_step_y_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_step_y[STEPY_BITS-1] && rsp_step_y[STEPY_BITS-2]
                      && rsp_step_y[STEPY_BITS-3:0] == '0)
                    && !(rsp_step_y[STEPY_BITS-1] && !rsp_step_y[STEPY_BITS-2]))
      else $error("y step out of range");

endmodule

bind mouse_packet_cursor_tracker mpct_checker #(.COORD_BITS(COORD_BITS)) u_mpct_checker (.*);

>>> tb/tb_mouse_packet_cursor_tracker.sv
// ----------------------------------------------------------------------------
// tb_mouse_packet_cursor_tracker: self-checking bench for the cursor tracker
// Drives PS/2 packets through the valid/stall request channel and checks
// every response word against an in-bench model of the decoder and the
// clamped cursor. A short table of directed packets and register writes
// comes first. Random packets follow under several screen sizes and
// several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_mouse_packet_cursor_tracker;

   import mpct_pkg::*;

   localparam int COORD_W    = COORD_BITS_DEFAULT;
   localparam int PHASES     = 8;
   localparam int PHASE_PKTS = 125;
   localparam int MAX_SHOWN  = 10;

   // Register indexes the block does not decode
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED_LO = 4'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED_HI = 4'd15;

   // One response word
   typedef struct packed {
      button_type                    btn;
      logic signed [STEPX_BITS-1:0]  step_x;
      logic signed [STEPY_BITS-1:0]  step_y;
      logic [COORD_W-1:0]            col;
      logic [COORD_W-1:0]            row;
   } cursor_report_type;

   typedef enum logic {ROW_PACKET, ROW_WRITE} row_kind_type;

   // One row of the directed table
   typedef struct {
      row_kind_type             kind;
      logic [CSR_IDX_BITS-1:0]  idx;
      logic [SIZE_BITS-1:0]     data;
      logic [BYTE_BITS-1:0]     st;
      logic [BYTE_BITS-1:0]     xb;
      logic [BYTE_BITS-1:0]     yb;
      bit                       typed;
      cursor_report_type        want;
   } stim_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [BYTE_BITS-1:0]          req_status_byte = '0;
   logic [BYTE_BITS-1:0]          req_x_move_byte = '0;
   logic [BYTE_BITS-1:0]          req_y_move_byte = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_left_pressed;
   logic                          rsp_right_pressed;
   logic                          rsp_middle_pressed;
   logic                          rsp_any_pressed;
   logic signed [STEPX_BITS-1:0]  rsp_step_x;
   logic signed [STEPY_BITS-1:0]  rsp_step_y;
   logic [COORD_W-1:0]            rsp_cursor_col;
   logic [COORD_W-1:0]            rsp_cursor_row;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_IDX_BITS-1:0]       csr_index = '0;
   logic [SIZE_BITS-1:0]          csr_data = '0;

   // Model state: screen size shadows and cursor position
   logic [SIZE_BITS-1:0]  shadow_wide;
   logic [SIZE_BITS-1:0]  shadow_tall;
   int                    track_col;
   int                    track_row;

   cursor_report_type  pending_reports[$];
   stim_row_type       directed_rows[$];
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   int              fault_count = 0;
   int              packets_sent = 0;
   int              reports_seen = 0;

   mouse_packet_cursor_tracker dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_status_byte    (req_status_byte),
      .req_x_move_byte    (req_x_move_byte),
      .req_y_move_byte    (req_y_move_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_left_pressed   (rsp_left_pressed),
      .rsp_right_pressed  (rsp_right_pressed),
      .rsp_middle_pressed (rsp_middle_pressed),
      .rsp_any_pressed    (rsp_any_pressed),
      .rsp_step_x         (rsp_step_x),
      .rsp_step_y         (rsp_step_y),
      .rsp_cursor_col     (rsp_cursor_col),
      .rsp_cursor_row     (rsp_cursor_row),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #4 clock = ~clock;

   // Clamp a coordinate into 0..size-1; size 0 acts as 1, large sizes cap
   function automatic int clamp_to_screen(int v, logic [SIZE_BITS-1:0] size);
      int lim;
      if (size == 0) begin
         lim = 1;
      end else if (size > (1 << COORD_W)) begin
         lim = 1 << COORD_W;
      end else begin
         lim = size;
      end
      if (v < 0) begin
         return 0;
      end
      return (v > lim - 1) ? lim - 1 : v;
   endfunction

   // Decode one packet and move the tracked cursor
   function automatic cursor_report_type predict_packet(logic [7:0] st, logic [7:0] xb,
                                                        logic [7:0] yb);
      cursor_report_type r;
      int dx;
      int dy;
      int sx;
      int sy;
      dx = st[ST_XSIGN] ? int'(xb) - 256 : int'(xb);
      dy = st[ST_YSIGN] ? int'(yb) - 256 : int'(yb);
      sx = st[ST_XOVF] ? 0 : dx;
      sy = st[ST_YOVF] ? 0 : -dy;
      track_col = clamp_to_screen(track_col + sx, shadow_wide);
      track_row = clamp_to_screen(track_row + sy, shadow_tall);
      r.btn.left   = st[ST_LEFT];
      r.btn.right  = st[ST_RIGHT];
      r.btn.middle = st[ST_MID];
      r.btn.any    = st[ST_LEFT] | st[ST_RIGHT] | st[ST_MID];
      r.step_x     = sx[STEPX_BITS-1:0];
      r.step_y     = sy[STEPY_BITS-1:0];
      r.col        = track_col[COORD_W-1:0];
      r.row        = track_row[COORD_W-1:0];
      return r;
   endfunction

   // Directed table row builders
   function automatic stim_row_type pkt(logic [7:0] st, logic [7:0] xb, logic [7:0] yb);
      stim_row_type s;
      s = '{kind: ROW_PACKET, idx: '0, data: '0, st: st, xb: xb, yb: yb,
            typed: 1'b0, want: '0};
      return s;
   endfunction

   function automatic stim_row_type pkt_chk(logic [7:0] st, logic [7:0] xb, logic [7:0] yb,
                                            logic [3:0] btn, int sx, int sy,
                                            int col, int row);
      stim_row_type s;
      s = pkt(st, xb, yb);
      s.typed       = 1'b1;
      s.want.btn    = btn;
      s.want.step_x = sx[STEPX_BITS-1:0];
      s.want.step_y = sy[STEPY_BITS-1:0];
      s.want.col    = col[COORD_W-1:0];
      s.want.row    = row[COORD_W-1:0];
      return s;
   endfunction

   function automatic stim_row_type reg_wr(logic [CSR_IDX_BITS-1:0] idx,
                                           logic [SIZE_BITS-1:0] data);
      stim_row_type s;
      s = pkt('0, '0, '0);
      s.kind = ROW_WRITE;
      s.idx  = idx;
      s.data = data;
      return s;
   endfunction

   // Send one packet word; holds it until accepted, then records the result
   task automatic send_packet(logic [7:0] st, logic [7:0] xb, logic [7:0] yb,
                              bit typed, cursor_report_type want);
      cursor_report_type model;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_status_byte <= st;
      req_x_move_byte <= xb;
      req_y_move_byte <= yb;
      do @(posedge clock); while (req_stall);
      model = predict_packet(st, xb, yb);
      pending_reports.push_back(typed ? want : model);
      packets_sent++;
   endtask

   // Stop sending and wait until every expected word has come back
   task automatic settle(int extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   // Register write; csr_valid stays high for back-to-back writes
   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [SIZE_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SCREEN_WIDE) begin
         shadow_wide = data;
      end else if (idx == CSR_SCREEN_TALL) begin
         shadow_tall = data;
      end
   endtask

   task automatic end_writes();
      csr_valid <= 1'b0;
   endtask

   // Response checker and receiver stall
   always @(posedge clock) begin : rsp_check
      cursor_report_type got;
      cursor_report_type want;
      bit bad;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.btn.left   = rsp_left_pressed;
            got.btn.right  = rsp_right_pressed;
            got.btn.middle = rsp_middle_pressed;
            got.btn.any    = rsp_any_pressed;
            got.step_x     = rsp_step_x;
            got.step_y     = rsp_step_y;
            got.col        = rsp_cursor_col;
            got.row        = rsp_cursor_row;
            reports_seen++;
            if (pending_reports.size() == 0) begin
               fault_count++;
               if (fault_count <= MAX_SHOWN) begin
                  $display("unexpected response word %0d: btn=%b sx=%0d sy=%0d col=%0d row=%0d",
                           reports_seen, got.btn, got.step_x, got.step_y, got.col, got.row);
               end
            end else begin
               want = pending_reports.pop_front();
               bad = (got.btn.left !== want.btn.left) || (got.btn.right !== want.btn.right)
                  || (got.btn.middle !== want.btn.middle) || (got.btn.any !== want.btn.any)
                  || (got.step_x !== want.step_x) || (got.step_y !== want.step_y)
                  || (got.col !== want.col) || (got.row !== want.row);
               if (bad) begin
                  fault_count++;
                  if (fault_count <= MAX_SHOWN) begin
                     $display("word %0d mismatch: exp btn=%b sx=%0d sy=%0d col=%0d row=%0d",
                              reports_seen, want.btn, want.step_x, want.step_y,
                              want.col, want.row);
                     $display("                   got btn=%b sx=%0d sy=%0d col=%0d row=%0d",
                              got.btn, got.step_x, got.step_y, got.col, got.row);
                  end
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Hard stop
   initial begin
      #3200000;
      $display("mouse_packet_cursor_tracker verification failed");
      $finish;
   end

   // Stimulus
   initial begin : stimulus
      stim_row_type       r;
      cursor_report_type  none;
      logic [7:0]      st;
      logic [7:0]      xb;
      logic [7:0]      yb;
      logic [2:0]      btns;
      int              kind;
      int              dx;
      int              dy;
      logic [SIZE_BITS-1:0] wide_set[PHASES];
      logic [SIZE_BITS-1:0] tall_set[PHASES];

      none = '0;
      shadow_wide = SCREEN_WIDE_RESET;
      shadow_tall = SCREEN_TALL_RESET;
      track_col = clamp_to_screen(int'(SCREEN_WIDE_RESET) / 2, SCREEN_WIDE_RESET);
      track_row = clamp_to_screen(int'(SCREEN_TALL_RESET) / 2, SCREEN_TALL_RESET);

      // Directed: buttons, sign and overflow bits, clamps, odd sizes
      directed_rows.push_back(pkt_chk(8'h08, 8'h00, 8'h00, 4'b0000, 0, 0, 320, 240));
      directed_rows.push_back(pkt_chk(8'h0F, 8'h00, 8'h00, 4'b1111, 0, 0, 320, 240));
      directed_rows.push_back(pkt_chk(8'h01, 8'h00, 8'h00, 4'b1001, 0, 0, 320, 240));
      directed_rows.push_back(pkt_chk(8'h02, 8'h00, 8'h00, 4'b0101, 0, 0, 320, 240));
      directed_rows.push_back(pkt_chk(8'h04, 8'h00, 8'h00, 4'b0011, 0, 0, 320, 240));
      directed_rows.push_back(pkt_chk(8'h00, 8'hFF, 8'h00, 4'b0000, 255, 0, 575, 240));
      directed_rows.push_back(pkt_chk(8'h10, 8'h00, 8'h00, 4'b0000, -256, 0, 319, 240));
      directed_rows.push_back(pkt_chk(8'h20, 8'h00, 8'h00, 4'b0000, 0, 256, 319, 479));
      directed_rows.push_back(pkt_chk(8'h00, 8'h00, 8'hFF, 4'b0000, 0, -255, 319, 224));
      directed_rows.push_back(pkt_chk(8'hC0, 8'hFF, 8'hFF, 4'b0000, 0, 0, 319, 224));
      directed_rows.push_back(pkt_chk(8'hF7, 8'h80, 8'h80, 4'b1111, 0, 0, 319, 224));
      directed_rows.push_back(pkt_chk(8'h10, 8'h00, 8'h00, 4'b0000, -256, 0, 63, 224));
      directed_rows.push_back(pkt_chk(8'h10, 8'h00, 8'h00, 4'b0000, -256, 0, 0, 224));
      directed_rows.push_back(pkt_chk(8'h18, 8'hFF, 8'h00, 4'b0000, -1, 0, 0, 224));
      directed_rows.push_back(pkt_chk(8'h00, 8'hFF, 8'h00, 4'b0000, 255, 0, 255, 224));
      directed_rows.push_back(pkt_chk(8'h00, 8'hFF, 8'h00, 4'b0000, 255, 0, 510, 224));
      directed_rows.push_back(pkt_chk(8'h00, 8'hFF, 8'h00, 4'b0000, 255, 0, 639, 224));
      // zero width pins the column at 0 from the next packet on
      directed_rows.push_back(reg_wr(CSR_SCREEN_WIDE, 13'd0));
      directed_rows.push_back(pkt_chk(8'h08, 8'h00, 8'h00, 4'b0000, 0, 0, 0, 224));
      // undecoded index is ignored; oversized width, zero height
      directed_rows.push_back(reg_wr(CSR_UNUSED_LO, 13'd5));
      directed_rows.push_back(reg_wr(CSR_SCREEN_WIDE, 13'h1FFF));
      directed_rows.push_back(reg_wr(CSR_SCREEN_TALL, 13'd0));
      directed_rows.push_back(pkt_chk(8'h00, 8'hFF, 8'h00, 4'b0000, 255, 0, 255, 0));
      directed_rows.push_back(pkt(8'h00, 8'hFF, 8'h00));
      directed_rows.push_back(reg_wr(CSR_UNUSED_HI, 13'h1FFF));
      directed_rows.push_back(reg_wr(CSR_SCREEN_TALL, 13'd4096));
      directed_rows.push_back(pkt(8'h20, 8'h00, 8'h00));
      directed_rows.push_back(pkt(8'h2B, 8'h7F, 8'h01));

      // Screen settings for the random phases
      wide_set = '{13'd640, 13'd0, 13'd1, 13'd4096, 13'h1FFF, 13'd4097, 13'd0, 13'd0};
      tall_set = '{13'd480, 13'd0, 13'd1, 13'd4096, 13'h1FFF, 13'd1, 13'd0, 13'd0};
      wide_set[6] = SIZE_BITS'($urandom_range(1, 64));
      tall_set[6] = SIZE_BITS'($urandom_range(1, 64));
      wide_set[7] = SIZE_BITS'($urandom_range(0, 8191));
      tall_set[7] = SIZE_BITS'($urandom_range(0, 8191));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         if (r.kind == ROW_WRITE) begin
            settle(2);
            write_reg(r.idx, r.data);
            end_writes();
         end else begin
            send_packet(r.st, r.xb, r.yb, r.typed, r.want);
         end
      end

      // Random phases, each with its own size and one of four idle and stall patterns
      for (int ph = 0; ph < PHASES; ph++) begin
         settle(2);
         send_idle_pct  = 0;
         recv_stall_pct = 0;
         write_reg(CSR_SCREEN_WIDE, wide_set[ph]);
         write_reg(CSR_SCREEN_TALL, tall_set[ph]);
         if ($urandom_range(0, 1) == 1) begin
            write_reg(CSR_IDX_BITS'($urandom_range(2, 15)), SIZE_BITS'($urandom_range(0, 8191)));
         end
         end_writes();
         case (ph % 4)
            1: begin
               send_idle_pct = 65;
            end
            2: begin
               recv_stall_pct = 65;
            end
            3: begin
               send_idle_pct  = 24;
               recv_stall_pct = 24;
            end
            default: begin
               send_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < PHASE_PKTS; n++) begin
            // sender holds off now and then until the pipe is empty
            if (n == PHASE_PKTS / 2 || $urandom_range(0, 199) == 0) begin
               settle(0);
            end
            kind = $urandom_range(0, 9);
            btns = 3'($urandom_range(0, 7));
            if (kind < 6) begin
               // well-formed packet with a small movement
               dx = int'($urandom_range(0, 40)) - 20;
               dy = int'($urandom_range(0, 40)) - 20;
               xb = dx[7:0];
               yb = dy[7:0];
               st = {2'b00, dy[8], dx[8], 1'b1, btns};
            end else if (kind < 8) begin
               // well-formed packet with a full-range movement
               xb = 8'($urandom_range(0, 255));
               yb = 8'($urandom_range(0, 255));
               st = {2'b00, 2'($urandom_range(0, 3)), 1'b1, btns};
            end else if (kind == 8) begin
               st = 8'($urandom_range(0, 255));
               xb = 8'($urandom_range(0, 255));
               yb = 8'($urandom_range(0, 255));
            end else begin
               // overflow flagged on one or both axes
               st = 8'($urandom_range(0, 255));
               st[7:6] = 2'($urandom_range(1, 3));
               xb = 8'($urandom_range(0, 255));
               yb = 8'($urandom_range(0, 255));
            end
            send_packet(st, xb, yb, 1'b0, none);
         end
      end

      settle(4);
      $display("sent %0d packets over %0d screen settings plus directed rows;",
               packets_sent, PHASES);
      $display("checked %0d response words, %0d mismatches", reports_seen, fault_count);
      if (fault_count == 0 && pending_reports.size() == 0) begin
         $display("mouse_packet_cursor_tracker verification clean");
      end else begin
         $display("mouse_packet_cursor_tracker verification failed");
      end
      $finish;
   end

endmodule
